[sv/lhist_pkg.sv]
// Shared constants and types of the line profile histogram.
package lhist_pkg;

    localparam int BIN_COUNT     = 256;
    localparam int BIN_W         = $clog2(BIN_COUNT);
    localparam int COUNT_W       = 13;
    localparam int COUNT_LIMIT   = 4096;
    localparam int MAX_DIMENSION = 4096;
    localparam int POS_W         = $clog2(MAX_DIMENSION);
    localparam int WIDTH_W       = POS_W + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SELECT_ROW  = 2'd0,
        REG_LINE_INDEX  = 2'd1,
        REG_IMAGE_WIDTH = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_READ  = 1'b1
    } item_kind_t;

endpackage

[sv/lhist_in_if.sv]
// Input channel carrying pixel and read items.
interface lhist_in_if;
    import lhist_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [7:0]       pixel_value;
    logic             start_of_image;
    logic [BIN_W-1:0] bin_index;

    modport source (output valid, output kind, output pixel_value,
                    output start_of_image, output bin_index, input ready);
    modport sink   (input valid, input kind, input pixel_value,
                    input start_of_image, input bin_index, output ready);
endinterface

[sv/lhist_out_if.sv]
// Output channel carrying bin counts.
interface lhist_out_if;
    import lhist_pkg::*;

    logic               valid;
    logic               ready;
    logic [BIN_W-1:0]   bin_number;
    logic [COUNT_W-1:0] bin_count;

    modport source (output valid, output bin_number, output bin_count, input ready);
    modport sink   (input valid, input bin_number, input bin_count, output ready);
endinterface

[sv/line_profile_histogram_top.sv]
// Line profile histogram: counts pixel intensities of one row or column in a bin memory.
// The block takes one item per clock unless the input is held. The bin memory is read at the
// edge that takes an item, and the update and write-back follow in the next stage; a write to
// the same bin in the cycle of a read is forwarded. Read results pass from the first-stage
// registers into an output register and wait there; only a read item meeting a full, stalled
// output register holds the input, so pixel items keep flowing while a result waits. Bins are
// cleared at reset by per-bin valid flags, so no clearing pass is needed; a read clears its bin.
module line_profile_histogram_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lhist_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lhist_pkg::CFG_DATA_W-1:0] cfg_data,
    lhist_in_if.sink                       pixel_in,
    lhist_out_if.source                    result_out
);
    import lhist_pkg::*;

    logic               select_row_reg;
    logic [POS_W-1:0]   line_index_reg;
    logic [WIDTH_W-1:0] image_width_reg;

    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;

    logic               s1_valid_reg;
    logic               s1_read_reg;
    logic               s1_hit_reg;
    logic [BIN_W-1:0]   s1_addr_reg;

    logic [COUNT_W-1:0] bin_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] bin_valid_reg;
    logic [COUNT_W-1:0] mem_q_reg;

    logic               last_we_reg;
    logic [BIN_W-1:0]   last_addr_reg;
    logic [COUNT_W-1:0] last_data_reg;

    logic               out_valid_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               advance;
    logic               accept;
    logic               accept_pixel;
    logic [POS_W-1:0]   cur_col;
    logic [POS_W-1:0]   cur_row;
    logic               hit;
    logic [WIDTH_W-1:0] eff_width;
    logic [COUNT_W-1:0] old_count;
    logic               wr_en;
    logic [COUNT_W-1:0] wr_data;

    assign advance      = !(s1_valid_reg && s1_read_reg && out_valid_reg && !result_out.ready);
    assign pixel_in.ready = advance;
    assign accept       = pixel_in.valid && advance;
    assign accept_pixel = accept && (pixel_in.kind == KIND_PIXEL);

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_width = WIDTH_W'(1);
        end
        else if (image_width_reg > WIDTH_W'(MAX_DIMENSION))
        begin
            eff_width = WIDTH_W'(MAX_DIMENSION);
        end
        else
        begin
            eff_width = image_width_reg;
        end

        cur_col = pixel_in.start_of_image ? '0 : col_reg;
        cur_row = pixel_in.start_of_image ? '0 : row_reg;
        hit = select_row_reg ? (cur_row == line_index_reg) : (cur_col == line_index_reg);

        col_next = col_reg;
        row_next = row_reg;
        if (accept_pixel)
        begin
            if ({1'b0, cur_col} + WIDTH_W'(1) >= eff_width)
            begin
                col_next = '0;
                row_next = cur_row + POS_W'(1);
            end
            else
            begin
                col_next = cur_col + POS_W'(1);
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_row_reg  <= 1'b1;
            line_index_reg  <= '0;
            image_width_reg <= WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SELECT_ROW:  select_row_reg  <= cfg_data[0];
                REG_LINE_INDEX:  line_index_reg  <= cfg_data[POS_W-1:0];
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[WIDTH_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pixel_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_read_reg <= (pixel_in.kind == KIND_READ);
            s1_hit_reg  <= hit;
            s1_addr_reg <= (pixel_in.kind == KIND_READ) ? pixel_in.bin_index
                                                        : pixel_in.pixel_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mem_q_reg <= bin_mem[(pixel_in.kind == KIND_READ) ? pixel_in.bin_index
                                                              : pixel_in.pixel_value];
        end
    end

    always_comb
    begin
        if (last_we_reg && (last_addr_reg == s1_addr_reg))
        begin
            old_count = last_data_reg;
        end
        else if (bin_valid_reg[s1_addr_reg])
        begin
            old_count = mem_q_reg;
        end
        else
        begin
            old_count = '0;
        end

        wr_en   = 1'b0;
        wr_data = '0;
        if (s1_valid_reg && advance)
        begin
            if (s1_read_reg)
            begin
                wr_en = 1'b1;
            end
            else if (s1_hit_reg && (old_count < COUNT_W'(COUNT_LIMIT)))
            begin
                wr_en   = 1'b1;
                wr_data = old_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[s1_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            last_we_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                bin_valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (advance)
            begin
                last_we_reg <= wr_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last_addr_reg <= s1_addr_reg;
            last_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_read_reg && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_read_reg && advance)
        begin
            out_bin_reg   <= s1_addr_reg;
            out_count_reg <= old_count;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.bin_number = out_bin_reg;
    assign result_out.bin_count  = out_count_reg;

endmodule

[sv/lhist_checker.sv]
// Port-level checks of the line profile histogram and their binding to the top level.
module lhist_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           in_kind,
    input logic [lhist_pkg::BIN_W-1:0]    in_bin_index,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [lhist_pkg::BIN_W-1:0]    out_bin_number,
    input logic [lhist_pkg::COUNT_W-1:0]  out_bin_count
);
    import lhist_pkg::*;

    logic read_transfer;

    assign read_transfer = in_valid && in_ready && (in_kind == KIND_READ);

    // A waiting result holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bin_number)
            && $stable(out_bin_count))
        else $error("result changed while stalled");

    // A bin count never exceeds the saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_bin_count <= COUNT_W'(COUNT_LIMIT)))
        else $error("bin count above limit");

    // Reading a bin twice in a row returns zero the second time.
    assert property (@(posedge clk) disable iff (!rst_n)
        read_transfer ##1 (read_transfer && (in_bin_index == $past(in_bin_index)))
            ##1 out_ready |=> out_valid && (out_bin_count == '0))
        else $error("cleared bin returned a non-zero count");

endmodule

bind line_profile_histogram_top lhist_checker u_lhist_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pixel_in.valid),
    .in_ready       (pixel_in.ready),
    .in_kind        (pixel_in.kind),
    .in_bin_index   (pixel_in.bin_index),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .out_bin_number (result_out.bin_number),
    .out_bin_count  (result_out.bin_count)
);
